FILE: rtl/core/cmd_pkg.sv
// Shared types and constants for the chat message deframer.
`timescale 1ns / 1ps

package cmd_pkg;

    localparam int MAX_CONTENT_DEF = 1023;

    localparam logic [2:0] HDR_LEN      = 3'd6;
    localparam logic [2:0] ADDR_LEN     = 3'd4;
    localparam logic [7:0] NEWLINE_BYTE = 8'h0A;
    localparam logic [7:0] START_MSG    = 8'h00;
    localparam logic [7:0] START_SHUT   = 8'h01;

    typedef enum logic [1:0] {
        PH_IDLE    = 2'd0,
        PH_HEADER  = 2'd1,
        PH_CONTENT = 2'd2,
        PH_SHUT    = 2'd3
    } phase_t;

    typedef enum logic [1:0] {
        KIND_CONTENT  = 2'd0,
        KIND_END      = 2'd1,
        KIND_SHUTDOWN = 2'd2
    } kind_t;

    typedef struct packed {
        kind_t       kind;
        logic [7:0]  data_byte;
        logic [31:0] sender_addr;
        logic [15:0] src_port;
        logic        overflow;
    } result_t;

endpackage

FILE: rtl/core/cmd_parse.sv
// Message framing state machine: header capture, content limit, result build.
`timescale 1ns / 1ps

module cmd_parse #(
    parameter int MAX_CONTENT = cmd_pkg::MAX_CONTENT_DEF
) (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             accept,
    input  logic [7:0]       in_byte,
    output logic             res_valid,
    output cmd_pkg::result_t res
);

    localparam int CntW = $clog2(MAX_CONTENT + 1);
    localparam logic [CntW-1:0] CntMax = CntW'(MAX_CONTENT);

    cmd_pkg::phase_t phase_reg, phase_next;
    logic [2:0]      header_count_reg, header_count_next;
    logic [31:0]     addr_reg, addr_next;
    logic [15:0]     port_reg, port_next;
    logic [CntW-1:0] content_count_reg, content_count_next;
    logic            dropped_reg, dropped_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg         <= cmd_pkg::PH_IDLE;
            header_count_reg  <= '0;
            addr_reg          <= '0;
            port_reg          <= '0;
            content_count_reg <= '0;
            dropped_reg       <= 1'b0;
        end
        else if (accept)
        begin
            phase_reg         <= phase_next;
            header_count_reg  <= header_count_next;
            addr_reg          <= addr_next;
            port_reg          <= port_next;
            content_count_reg <= content_count_next;
            dropped_reg       <= dropped_next;
        end
    end

    always_comb
    begin
        phase_next         = phase_reg;
        header_count_next  = header_count_reg;
        addr_next          = addr_reg;
        port_next          = port_reg;
        content_count_next = content_count_reg;
        dropped_next       = dropped_reg;
        res_valid          = 1'b0;
        res.kind           = cmd_pkg::KIND_CONTENT;
        res.data_byte      = 8'd0;
        res.sender_addr    = addr_reg;
        res.src_port       = port_reg;
        res.overflow       = 1'b0;

        case (phase_reg)
            cmd_pkg::PH_IDLE:
            begin
                if (in_byte == cmd_pkg::START_SHUT)
                begin
                    phase_next      = cmd_pkg::PH_SHUT;
                    res_valid       = 1'b1;
                    res.kind        = cmd_pkg::KIND_SHUTDOWN;
                    res.sender_addr = 32'd0;
                    res.src_port    = 16'd0;
                end
                else if (in_byte == cmd_pkg::START_MSG)
                begin
                    phase_next         = cmd_pkg::PH_HEADER;
                    header_count_next  = '0;
                    addr_next          = '0;
                    port_next          = '0;
                    content_count_next = '0;
                    dropped_next       = 1'b0;
                end
            end

            cmd_pkg::PH_HEADER:
            begin
                // header bytes are data, a newline included
                if (header_count_reg < cmd_pkg::ADDR_LEN)
                    addr_next = {addr_reg[23:0], in_byte};
                else
                    port_next = {port_reg[7:0], in_byte};
                if (header_count_reg == cmd_pkg::HDR_LEN - 3'd1)
                begin
                    header_count_next = '0;
                    phase_next        = cmd_pkg::PH_CONTENT;
                end
                else
                    header_count_next = header_count_reg + 3'd1;
            end

            cmd_pkg::PH_CONTENT:
            begin
                if (in_byte == cmd_pkg::NEWLINE_BYTE)
                begin
                    res_valid          = 1'b1;
                    res.kind           = cmd_pkg::KIND_END;
                    res.overflow       = dropped_reg;
                    phase_next         = cmd_pkg::PH_IDLE;
                    content_count_next = '0;
                    dropped_next       = 1'b0;
                end
                else if (content_count_reg < CntMax)
                begin
                    content_count_next = content_count_reg + CntW'(1);
                    res_valid          = 1'b1;
                    res.data_byte      = in_byte;
                end
                else
                    dropped_next = 1'b1; // drop the byte, flag it at the end
            end

            default:
            begin
                res_valid = 1'b0;
            end
        endcase
    end

endmodule

FILE: rtl/core/cmd_out_buf.sv
// Two-entry output buffer that decouples result delivery from input acceptance.
`timescale 1ns / 1ps

module cmd_out_buf (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             push,
    input  cmd_pkg::result_t push_data,
    output logic             full,
    output logic             out_valid,
    input  logic             out_ready,
    output cmd_pkg::result_t out_data
);

    cmd_pkg::result_t slot_reg [2];
    logic             wr_ptr_reg, wr_ptr_next;
    logic             rd_ptr_reg, rd_ptr_next;
    logic [1:0]       count_reg, count_next;
    logic             pop;

    assign full      = (count_reg == 2'd2);
    assign out_valid = (count_reg != 2'd0);
    assign out_data  = slot_reg[rd_ptr_reg];
    assign pop       = out_valid && out_ready;

    always_comb
    begin
        wr_ptr_next = push ? ~wr_ptr_reg : wr_ptr_reg;
        rd_ptr_next = pop ? ~rd_ptr_reg : rd_ptr_reg;
        count_next  = count_reg + {1'b0, push} - {1'b0, pop};
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            count_reg  <= 2'd0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
            slot_reg[wr_ptr_reg] <= push_data;
    end

endmodule

FILE: rtl/core/chat_message_deframer_top.sv
// A result is written into the output buffer when its byte is accepted and is presented from there in order.
// Throughput: one byte per cycle; in_ready stays high while a result waits,
// dropping only when both entries of the two-entry output buffer are occupied.
// Reset clears the framing state (idle phase, counters, address and port)
// and empties the output buffer; no clearing pass is needed.
`timescale 1ns / 1ps

module chat_message_deframer_top #(
    parameter int MAX_CONTENT = cmd_pkg::MAX_CONTENT_DEF
) (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        in_valid,
    output logic        in_ready,
    input  logic [7:0]  in_byte,
    output logic        out_valid,
    input  logic        out_ready,
    output logic [1:0]  kind,
    output logic [7:0]  data_byte,
    output logic [31:0] sender_addr,
    output logic [15:0] src_port,
    output logic        overflow
);

    logic             accept;
    logic             res_valid;
    logic             buf_full;
    cmd_pkg::result_t res;
    cmd_pkg::result_t out_data;

    assign in_ready = !buf_full;
    assign accept   = in_valid && in_ready;

    cmd_parse #(
        .MAX_CONTENT (MAX_CONTENT)
    ) u_parse (
        .clk       (clk),
        .rst_n     (rst_n),
        .accept    (accept),
        .in_byte   (in_byte),
        .res_valid (res_valid),
        .res       (res)
    );

    cmd_out_buf u_out_buf (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (accept && res_valid),
        .push_data (res),
        .full      (buf_full),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .out_data  (out_data)
    );

    assign kind        = out_data.kind;
    assign data_byte   = out_data.data_byte;
    assign sender_addr = out_data.sender_addr;
    assign src_port    = out_data.src_port;
    assign overflow    = out_data.overflow;

endmodule

FILE: sim/tb_chat_message_deframer_top.sv
// Self-checking testbench for the chat message deframer: directed and random byte streams.
`timescale 1ns / 1ps

module tb_chat_message_deframer_top;

    localparam int CONTENT_LIMIT = cmd_pkg::MAX_CONTENT_DEF;
    localparam int ITEM_TARGET   = 1750;
    localparam int HOLD_CYCLES   = 300;
    localparam int DRAIN_LIMIT   = 20000;

    localparam cmd_pkg::result_t NO_RESULT       = '0;
    localparam cmd_pkg::result_t SHUTDOWN_RESULT =
        '{cmd_pkg::KIND_SHUTDOWN, 8'h00, 32'h0, 16'h0, 1'b0};

    typedef struct packed {
        logic [7:0]       data;
        logic             typed;
        cmd_pkg::result_t res;
    } stim_row_t;

    logic        clk;
    logic        rst_n;
    logic        in_valid;
    logic        in_ready;
    logic [7:0]  in_byte;
    logic        out_valid;
    logic        out_ready;
    logic [1:0]  kind;
    logic [7:0]  data_byte;
    logic [31:0] sender_addr;
    logic [15:0] src_port;
    logic        overflow;

    // Local copy of the framing state
    cmd_pkg::phase_t fr_phase;
    logic [2:0]      fr_hdr_count;
    logic [31:0]     fr_addr;
    logic [15:0]     fr_port;
    int              fr_content_count;
    logic            fr_dropped;

    cmd_pkg::result_t pending_results[$];
    int               bytes_sent;
    int               results_taken;
    int               mismatches;
    logic             steady;
    logic             shut_allowed;
    logic             held_off;

    // Empty message, newline in the header, extreme address and port, 0x01 as content,
    // unknown start bytes and a newline while idle
    stim_row_t directed_rows [25] = '{
        '{8'h7F, 1'b0, NO_RESULT},
        '{8'hFF, 1'b0, NO_RESULT},
        '{8'h00, 1'b0, NO_RESULT},
        '{8'h0A, 1'b0, NO_RESULT},
        '{8'hFF, 1'b0, NO_RESULT},
        '{8'h00, 1'b0, NO_RESULT},
        '{8'h80, 1'b0, NO_RESULT},
        '{8'h0A, 1'b0, NO_RESULT},
        '{8'hFF, 1'b0, NO_RESULT},
        '{8'h0A, 1'b1, '{cmd_pkg::KIND_END, 8'h00, 32'h0AFF0080, 16'h0AFF, 1'b0}},
        '{8'h00, 1'b0, NO_RESULT},
        '{8'hFF, 1'b0, NO_RESULT},
        '{8'hFF, 1'b0, NO_RESULT},
        '{8'hFF, 1'b0, NO_RESULT},
        '{8'hFF, 1'b0, NO_RESULT},
        '{8'hFF, 1'b0, NO_RESULT},
        '{8'hFF, 1'b0, NO_RESULT},
        '{8'h00, 1'b1, '{cmd_pkg::KIND_CONTENT, 8'h00, 32'hFFFFFFFF, 16'hFFFF, 1'b0}},
        '{8'hFF, 1'b1, '{cmd_pkg::KIND_CONTENT, 8'hFF, 32'hFFFFFFFF, 16'hFFFF, 1'b0}},
        '{8'h01, 1'b1, '{cmd_pkg::KIND_CONTENT, 8'h01, 32'hFFFFFFFF, 16'hFFFF, 1'b0}},
        '{8'h55, 1'b0, NO_RESULT},
        '{8'hAA, 1'b0, NO_RESULT},
        '{8'h0A, 1'b1, '{cmd_pkg::KIND_END, 8'h00, 32'hFFFFFFFF, 16'hFFFF, 1'b0}},
        '{8'h02, 1'b0, NO_RESULT},
        '{8'h0A, 1'b0, NO_RESULT}
    };

    chat_message_deframer_top #(
        .MAX_CONTENT (CONTENT_LIMIT)
    ) dut (
        .clk         (clk),
        .rst_n       (rst_n),
        .in_valid    (in_valid),
        .in_ready    (in_ready),
        .in_byte     (in_byte),
        .out_valid   (out_valid),
        .out_ready   (out_ready),
        .kind        (kind),
        .data_byte   (data_byte),
        .sender_addr (sender_addr),
        .src_port    (src_port),
        .overflow    (overflow)
    );

    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    // Advance the framing state by one byte; return 1 with the result where one is due
    function automatic logic frame_predict(input logic [7:0] b,
                                           output cmd_pkg::result_t r);
        r = NO_RESULT;
        case (fr_phase)
            cmd_pkg::PH_IDLE:
            begin
                if (b == cmd_pkg::START_SHUT)
                begin
                    fr_phase = cmd_pkg::PH_SHUT;
                    r = SHUTDOWN_RESULT;
                    return 1'b1;
                end
                if (b == cmd_pkg::START_MSG)
                begin
                    fr_phase         = cmd_pkg::PH_HEADER;
                    fr_hdr_count     = '0;
                    fr_addr          = '0;
                    fr_port          = '0;
                    fr_content_count = 0;
                    fr_dropped       = 1'b0;
                end
                return 1'b0;
            end
            cmd_pkg::PH_HEADER:
            begin
                if (fr_hdr_count < cmd_pkg::ADDR_LEN)
                    fr_addr = {fr_addr[23:0], b};
                else
                    fr_port = {fr_port[7:0], b};
                fr_hdr_count = fr_hdr_count + 3'd1;
                if (fr_hdr_count == cmd_pkg::HDR_LEN)
                begin
                    fr_hdr_count = '0;
                    fr_phase     = cmd_pkg::PH_CONTENT;
                end
                return 1'b0;
            end
            cmd_pkg::PH_CONTENT:
            begin
                if (b == cmd_pkg::NEWLINE_BYTE)
                begin
                    r.kind           = cmd_pkg::KIND_END;
                    r.sender_addr    = fr_addr;
                    r.src_port       = fr_port;
                    r.overflow       = fr_dropped;
                    fr_phase         = cmd_pkg::PH_IDLE;
                    fr_content_count = 0;
                    fr_dropped       = 1'b0;
                    return 1'b1;
                end
                if (fr_content_count < CONTENT_LIMIT)
                begin
                    fr_content_count++;
                    r.kind        = cmd_pkg::KIND_CONTENT;
                    r.data_byte   = b;
                    r.sender_addr = fr_addr;
                    r.src_port    = fr_port;
                    return 1'b1;
                end
                fr_dropped = 1'b1;
                return 1'b0;
            end
            default:
                return 1'b0;
        endcase
    endfunction

    task automatic send_byte(input logic [7:0] b, input logic typed,
                             input cmd_pkg::result_t typed_res);
        int               gap;
        int               r;
        cmd_pkg::result_t pred;
        logic             has_result;
        // keep shutdown back for the end of the run
        if (!shut_allowed && fr_phase == cmd_pkg::PH_IDLE && b == cmd_pkg::START_SHUT)
            b = 8'($urandom_range(2, 255));
        r = $urandom_range(0, 99);
        if (steady || r < 55)
            gap = 0;
        else if (r < 90)
            gap = $urandom_range(1, 3);
        else
            gap = $urandom_range(6, 25);
        if (gap > 0)
        begin
            @(negedge clk);
            in_valid <= 1'b0;
            repeat (gap - 1) @(negedge clk);
        end
        @(negedge clk);
        in_valid <= 1'b1;
        in_byte  <= b;
        @(posedge clk);
        while (!in_ready)
            @(posedge clk);
        has_result = frame_predict(b, pred);
        if (has_result)
            pending_results.push_back(typed ? typed_res : pred);
        bytes_sent++;
    endtask

    task automatic send_message(input int n_content);
        logic [7:0] b;
        int         r;
        send_byte(cmd_pkg::START_MSG, 1'b0, NO_RESULT);
        for (int i = 0; i < int'(cmd_pkg::HDR_LEN); i++)
        begin
            r = $urandom_range(0, 99);
            if (r < 20)
                b = cmd_pkg::NEWLINE_BYTE;
            else if (r < 30)
                b = 8'h00;
            else if (r < 40)
                b = 8'hFF;
            else
                b = 8'($urandom_range(0, 255));
            send_byte(b, 1'b0, NO_RESULT);
        end
        for (int i = 0; i < n_content; i++)
        begin
            do
                b = 8'($urandom_range(0, 255));
            while (b == cmd_pkg::NEWLINE_BYTE);
            send_byte(b, 1'b0, NO_RESULT);
        end
        send_byte(cmd_pkg::NEWLINE_BYTE, 1'b0, NO_RESULT);
    endtask

    // Bring the framer back to idle after a broken sequence
    task automatic close_frame();
        while (fr_phase == cmd_pkg::PH_HEADER)
            send_byte(8'($urandom_range(0, 255)), 1'b0, NO_RESULT);
        if (fr_phase == cmd_pkg::PH_CONTENT)
            send_byte(cmd_pkg::NEWLINE_BYTE, 1'b0, NO_RESULT);
    endtask

    // Alternate between stretches with random idling and stretches without
    initial
    begin
        steady = 1'b0;
        forever
        begin
            repeat ($urandom_range(150, 400)) @(posedge clk);
            steady = ~steady;
        end
    end

    // Receiver: random stalls, plus one long hold-off to fill the block
    initial
    begin
        int stall;
        stall    = 0;
        held_off = 1'b0;
        wait (rst_n === 1'b1);
        forever
        begin
            @(negedge clk);
            if (!held_off && results_taken >= 150)
            begin
                held_off = 1'b1;
                out_ready <= 1'b0;
                repeat (HOLD_CYCLES) @(negedge clk);
            end
            else if (stall > 0)
            begin
                out_ready <= 1'b0;
                stall--;
            end
            else
            begin
                out_ready <= 1'b1;
                if (!steady && $urandom_range(0, 99) < 20)
                    stall = ($urandom_range(0, 9) == 0) ? $urandom_range(10, 30)
                                                         : $urandom_range(1, 3);
            end
        end
    end

    always @(posedge clk)
    begin
        cmd_pkg::result_t e;
        if (rst_n && out_valid && out_ready)
        begin
            results_taken++;
            if (pending_results.size() == 0)
            begin
                if (mismatches < 10)
                    $display("unexpected item: kind %0d data %02h addr %08h port %04h ovf %0b",
                             kind, data_byte, sender_addr, src_port, overflow);
                mismatches++;
            end
            else
            begin
                e = pending_results.pop_front();
                if (kind !== e.kind || data_byte !== e.data_byte ||
                    sender_addr !== e.sender_addr || src_port !== e.src_port ||
                    overflow !== e.overflow)
                begin
                    if (mismatches < 10)
                    begin
                        $display("mismatch: exp kind %0d data %02h addr %08h port %04h ovf %0b",
                                 e.kind, e.data_byte, e.sender_addr, e.src_port, e.overflow);
                        $display("          got kind %0d data %02h addr %08h port %04h ovf %0b",
                                 kind, data_byte, sender_addr, src_port, overflow);
                    end
                    mismatches++;
                end
            end
        end
    end

    initial
    begin
        #(5_000_000);
        $display("simulation failed");
        $finish;
    end

    initial
    begin
        int   r;
        int   spins;
        logic long_done;
        rst_n            = 1'b0;
        in_valid         = 1'b0;
        in_byte          = 8'h00;
        out_ready        = 1'b0;
        fr_phase         = cmd_pkg::PH_IDLE;
        fr_hdr_count     = '0;
        fr_addr          = '0;
        fr_port          = '0;
        fr_content_count = 0;
        fr_dropped       = 1'b0;
        bytes_sent       = 0;
        results_taken    = 0;
        mismatches       = 0;
        shut_allowed     = 1'b0;
        long_done        = 1'b0;
        repeat (11) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        foreach (directed_rows[i])
            send_byte(directed_rows[i].data, directed_rows[i].typed, directed_rows[i].res);

        while (bytes_sent < ITEM_TARGET)
        begin
            r = $urandom_range(0, 99);
            if (!long_done && bytes_sent > 500)
            begin
                // run past the content limit so the tail is dropped and flagged
                long_done = 1'b1;
                close_frame();
                send_message(CONTENT_LIMIT + $urandom_range(1, 6));
            end
            else if (r < 8)
                repeat ($urandom_range(1, 3))
                    send_byte(8'($urandom_range(0, 255)), 1'b0, NO_RESULT);
            else if (r < 14)
            begin
                send_byte(cmd_pkg::START_MSG, 1'b0, NO_RESULT);
                repeat ($urandom_range(0, 5))
                    send_byte(8'($urandom_range(0, 255)), 1'b0, NO_RESULT);
            end
            else
                send_message(($urandom_range(0, 9) == 0) ? 0 : $urandom_range(1, 40));
        end

        // Shutdown last: nothing after it may give a result
        close_frame();
        shut_allowed = 1'b1;
        send_byte(cmd_pkg::START_SHUT, 1'b1, SHUTDOWN_RESULT);
        repeat (20)
        begin
            r = $urandom_range(0, 3);
            send_byte((r == 0) ? cmd_pkg::START_MSG :
                      (r == 1) ? cmd_pkg::NEWLINE_BYTE : 8'($urandom_range(0, 255)),
                      1'b0, NO_RESULT);
        end
        @(negedge clk);
        in_valid <= 1'b0;

        spins = 0;
        while (pending_results.size() != 0 && spins < DRAIN_LIMIT)
        begin
            @(posedge clk);
            spins++;
        end
        if (pending_results.size() != 0)
        begin
            $display("simulation failed");
            $finish;
        end
        else
        begin
            repeat (8) @(posedge clk);
            if (mismatches == 0 && pending_results.size() == 0)
                $display("simulation ok");
            else
                $display("simulation failed");
            $finish;
        end
    end

endmodule
